[sv/deq_pkg.sv]
// Shared types and codes for the double-ended queue.
// Used by deq_ctrl, deq_datapath and double_ended_queue; no dependencies.
`default_nettype none

package deq_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned CMD_W  = 3;
   localparam int unsigned STAT_W = 2;
   localparam int unsigned OCC_W  = 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_PEEK_FRONT = 3'd4,
      CMD_PEEK_BACK  = 3'd5,
      CMD_CLEAR      = 3'd6
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_OVERFLOW  = 2'd1,
      STAT_UNDERFLOW = 2'd2
   } status_type;

   // Source of the read_value field of a response
   typedef enum logic [1:0] {
      RD_ZERO = 2'd0,
      RD_MEM  = 2'd1,
      RD_ONES = 2'd2
   } rd_sel_type;

   // Controller to datapath command
   typedef struct packed {
      logic load;     // execute the request transaction this cycle
      logic rsp_live; // a response is presented on the result channel
   } ctl_type;

endpackage

`default_nettype wire

[sv/double_ended_queue.sv]
// Double-ended queue of signed 32-bit words in a circular buffer of CAPACITY entries.
// Top level: instantiates deq_ctrl and deq_datapath; depends on deq_pkg.
//
// Each request transaction carries one command (push front/back, pop front/back,
// peek front/back, clear) and yields exactly one response transaction in the next
// cycle, with the popped or peeked word, a status (ok, overflow, underflow), the
// occupancy after the command (low 8 bits) and the empty and full flags. A new
// command is taken every cycle while responses are drained without stall, so the
// block sustains one command per cycle; the returned word comes from the registered
// read port of the word memory. Words in the memory are not cleared by reset or by
// the clear command; only words from occupied entries are ever returned.
`default_nettype none

module double_ended_queue #(
   parameter int unsigned CAPACITY = 128
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [deq_pkg::CMD_W-1:0]         req_command,
   input  wire logic signed [deq_pkg::WORD_W-1:0] req_push_value,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [deq_pkg::WORD_W-1:0]      rsp_read_value,
   output logic [deq_pkg::STAT_W-1:0]             rsp_status,
   output logic [deq_pkg::OCC_W-1:0]              rsp_occupancy,
   output logic                                   rsp_is_empty,
   output logic                                   rsp_is_full
);

   deq_pkg::ctl_type ctl;

   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctl       (ctl)
   );

   deq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .req_command    (req_command),
      .req_push_value (req_push_value),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_occupancy  (rsp_occupancy),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_is_full    (rsp_is_full)
   );

endmodule

`default_nettype wire

[sv/deq_datapath.sv]
// Datapath of the double-ended queue: word memory, pointers, count and response registers.
// Depends on deq_pkg; driven by deq_ctrl through deq_pkg::ctl_type.
`default_nettype none

module deq_datapath #(
   parameter int unsigned CAPACITY = 128
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire deq_pkg::ctl_type                  ctl,
   input  wire logic [deq_pkg::CMD_W-1:0]         req_command,
   input  wire logic signed [deq_pkg::WORD_W-1:0] req_push_value,
   output logic signed [deq_pkg::WORD_W-1:0]      rsp_read_value,
   output logic [deq_pkg::STAT_W-1:0]             rsp_status,
   output logic [deq_pkg::OCC_W-1:0]              rsp_occupancy,
   output logic                                   rsp_is_empty,
   output logic                                   rsp_is_full
);

   localparam int unsigned PTR_W = $clog2(CAPACITY);
   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

   logic [deq_pkg::WORD_W-1:0] mem [CAPACITY];

   logic [PTR_W-1:0] front_ff, front_in;
   logic [PTR_W-1:0] back_ff, back_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [deq_pkg::WORD_W-1:0] rd_data_ff;
   deq_pkg::rd_sel_type sel_ff, sel_in;
   deq_pkg::status_type status_ff, status_in;

   logic [PTR_W-1:0] front_inc, front_dec, back_inc, back_dec;
   logic [PTR_W-1:0] rd_addr, wr_addr;
   logic             wr_en;
   logic             is_full, is_empty;
   logic [31:0]      count_ext;

   assign front_inc = (front_ff == PTR_LAST) ? '0 : front_ff + 1'b1;
   assign front_dec = (front_ff == '0) ? PTR_LAST : front_ff - 1'b1;
   assign back_inc  = (back_ff == PTR_LAST) ? '0 : back_ff + 1'b1;
   assign back_dec  = (back_ff == '0) ? PTR_LAST : back_ff - 1'b1;
   assign is_full   = (count_ff == CNT_FULL);
   assign is_empty  = (count_ff == '0);

   always_comb begin
      front_in  = front_ff;
      back_in   = back_ff;
      count_in  = count_ff;
      sel_in    = deq_pkg::RD_ZERO;
      status_in = deq_pkg::STAT_OK;
      rd_addr   = front_ff;
      wr_addr   = back_ff;
      wr_en     = 1'b0;
      unique case (req_command)
         deq_pkg::CMD_PUSH_FRONT: begin
            if (is_full) begin
               status_in = deq_pkg::STAT_OVERFLOW;
            end else begin
               wr_en    = ctl.load;
               wr_addr  = front_dec;
               front_in = front_dec;
               count_in = count_ff + 1'b1;
            end
         end
         deq_pkg::CMD_PUSH_BACK: begin
            if (is_full) begin
               status_in = deq_pkg::STAT_OVERFLOW;
            end else begin
               wr_en    = ctl.load;
               wr_addr  = back_ff;
               back_in  = back_inc;
               count_in = count_ff + 1'b1;
            end
         end
         deq_pkg::CMD_POP_FRONT,
         deq_pkg::CMD_PEEK_FRONT: begin
            if (is_empty) begin
               status_in = deq_pkg::STAT_UNDERFLOW;
               sel_in    = deq_pkg::RD_ONES;
            end else begin
               sel_in  = deq_pkg::RD_MEM;
               rd_addr = front_ff;
               if (req_command == deq_pkg::CMD_POP_FRONT) begin
                  front_in = front_inc;
                  count_in = count_ff - 1'b1;
               end
            end
         end
         deq_pkg::CMD_POP_BACK,
         deq_pkg::CMD_PEEK_BACK: begin
            if (is_empty) begin
               status_in = deq_pkg::STAT_UNDERFLOW;
               sel_in    = deq_pkg::RD_ONES;
            end else begin
               sel_in  = deq_pkg::RD_MEM;
               rd_addr = back_dec;
               if (req_command == deq_pkg::CMD_POP_BACK) begin
                  back_in  = back_dec;
                  count_in = count_ff - 1'b1;
               end
            end
         end
         deq_pkg::CMD_CLEAR: begin
            front_in = '0;
            back_in  = '0;
            count_in = '0;
         end
         default: begin
            // unused code: no operation
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_push_value;
      end
      if (ctl.load) begin
         rd_data_ff <= mem[rd_addr];
         sel_ff     <= sel_in;
         status_ff  <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
         count_ff <= '0;
      end else if (ctl.load) begin
         front_ff <= front_in;
         back_ff  <= back_in;
         count_ff <= count_in;
      end
   end

   // Count and flags only change on load, so they hold while a response waits
   assign count_ext = 32'(count_ff);

   always_comb begin
      rsp_read_value = '0;
      rsp_status     = deq_pkg::STAT_OK;
      rsp_occupancy  = '0;
      rsp_is_empty   = 1'b0;
      rsp_is_full    = 1'b0;
      if (ctl.rsp_live) begin
         unique case (sel_ff)
            deq_pkg::RD_MEM:  rsp_read_value = rd_data_ff;
            deq_pkg::RD_ONES: rsp_read_value = '1;
            default:          rsp_read_value = '0;
         endcase
         rsp_status    = status_ff;
         rsp_occupancy = count_ext[deq_pkg::OCC_W-1:0];
         rsp_is_empty  = is_empty;
         rsp_is_full   = is_full;
      end
   end

endmodule

`default_nettype wire

[sv/deq_ctrl.sv]
// Handshake controller of the double-ended queue.
// Depends on deq_pkg; issues deq_pkg::ctl_type to deq_datapath.
`default_nettype none

module deq_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output deq_pkg::ctl_type      ctl
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_HOLD = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   // Take a new transaction whenever the response slot is free or being drained
   assign req_stall = (state_ff == S_HOLD) && rsp_stall;
   assign rsp_valid = (state_ff == S_HOLD);
   assign accept    = req_valid && !req_stall;

   assign ctl = '{load: accept, rsp_live: rsp_valid};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_HOLD;
         end
         S_HOLD: begin
            if (!rsp_stall && !accept) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[tb/sv/deq_response_checker.sv]
`timescale 1ns / 100ps
// Response checker for double_ended_queue: mirrors the deque on accepted commands,
// queues the predicted responses and compares each accepted response field by field.
// Depends on deq_pkg.

module deq_response_checker #(
   parameter int unsigned CAPACITY = 128
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [deq_pkg::CMD_W-1:0]         req_command,
   input  logic signed [deq_pkg::WORD_W-1:0] req_push_value,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic signed [deq_pkg::WORD_W-1:0] rsp_read_value,
   input  logic [deq_pkg::STAT_W-1:0]        rsp_status,
   input  logic [deq_pkg::OCC_W-1:0]         rsp_occupancy,
   input  logic                              rsp_is_empty,
   input  logic                              rsp_is_full,
   output int                                fail_count,
   output int                                outstanding
);

   localparam int unsigned FIELD_W = deq_pkg::WORD_W;

   typedef struct packed {
      logic signed [deq_pkg::WORD_W-1:0] read_value;
      deq_pkg::status_type               status;
      logic [deq_pkg::OCC_W-1:0]         occupancy;
      logic                              is_empty;
      logic                              is_full;
   } deq_reply_type;

   logic [deq_pkg::WORD_W-1:0] shadow_words [CAPACITY];
   int unsigned                front_idx;
   int unsigned                back_idx;
   int unsigned                stored_words;
   deq_reply_type              awaited_replies [$];
   deq_reply_type              oldest_reply;

   // Apply one command to the shadow deque and return the response it must produce
   function automatic deq_reply_type execute_command(
         input logic [deq_pkg::CMD_W-1:0]  cmd,
         input logic [deq_pkg::WORD_W-1:0] word);
      deq_reply_type reply;
      logic          full;
      logic          empty;
      full = (stored_words >= CAPACITY);
      empty = (stored_words == 0);
      reply.read_value = '0;
      reply.status = deq_pkg::STAT_OK;
      unique case (cmd)
         deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: begin
            if (full) begin
               reply.status = deq_pkg::STAT_OVERFLOW;
            end else if (cmd == deq_pkg::CMD_PUSH_FRONT) begin
               front_idx = (front_idx + CAPACITY - 1) % CAPACITY;
               shadow_words[front_idx] = word;
               stored_words++;
            end else begin
               shadow_words[back_idx] = word;
               back_idx = (back_idx + 1) % CAPACITY;
               stored_words++;
            end
         end
         deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK,
         deq_pkg::CMD_PEEK_FRONT, deq_pkg::CMD_PEEK_BACK: begin
            if (empty) begin
               reply.status = deq_pkg::STAT_UNDERFLOW;
               reply.read_value = '1;
            end else begin
               unique case (cmd)
                  deq_pkg::CMD_POP_FRONT: begin
                     reply.read_value = shadow_words[front_idx];
                     front_idx = (front_idx + 1) % CAPACITY;
                     stored_words--;
                  end
                  deq_pkg::CMD_POP_BACK: begin
                     back_idx = (back_idx + CAPACITY - 1) % CAPACITY;
                     reply.read_value = shadow_words[back_idx];
                     stored_words--;
                  end
                  deq_pkg::CMD_PEEK_FRONT: begin
                     reply.read_value = shadow_words[front_idx];
                  end
                  default: begin
                     reply.read_value = shadow_words[(back_idx + CAPACITY - 1) % CAPACITY];
                  end
               endcase
            end
         end
         deq_pkg::CMD_CLEAR: begin
            // words stay in memory, only the bookkeeping restarts
            front_idx = 0;
            back_idx = 0;
            stored_words = 0;
         end
         default: begin
         end
      endcase
      reply.occupancy = stored_words[deq_pkg::OCC_W-1:0];
      reply.is_empty = (stored_words == 0);
      reply.is_full = (stored_words == CAPACITY);
      return reply;
   endfunction

   task automatic check_field(input string field, input logic [FIELD_W-1:0] expected_val,
                              input logic [FIELD_W-1:0] actual_val);
      if (actual_val !== expected_val) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", field, expected_val, actual_val);
         fail_count++;
      end
   endtask

   // Compare the response first: it belongs to an earlier command than any taken this edge
   always @(posedge clock) begin
      if (reset) begin
         front_idx = 0;
         back_idx = 0;
         stored_words = 0;
         awaited_replies.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_replies.size() == 0) begin
               $error("response transaction with no command outstanding");
               fail_count++;
            end else begin
               oldest_reply = awaited_replies.pop_front();
               check_field("read_value", oldest_reply.read_value, rsp_read_value);
               check_field("status", FIELD_W'(oldest_reply.status), FIELD_W'(rsp_status));
               check_field("occupancy", FIELD_W'(oldest_reply.occupancy),
                           FIELD_W'(rsp_occupancy));
               check_field("is_empty", FIELD_W'(oldest_reply.is_empty),
                           FIELD_W'(rsp_is_empty));
               check_field("is_full", FIELD_W'(oldest_reply.is_full), FIELD_W'(rsp_is_full));
            end
         end
         if (req_valid && !req_stall) begin
            awaited_replies.push_back(execute_command(req_command, req_push_value));
         end
      end
      outstanding = awaited_replies.size();
   end

endmodule

[tb/sv/tb_double_ended_queue.sv]
`timescale 1ns / 100ps
// Testbench top for double_ended_queue: clock, reset, command stimulus and response stall.
// Depends on deq_pkg, double_ended_queue and deq_response_checker.

module tb_double_ended_queue;

   localparam int unsigned     CAPACITY    = 128;
   localparam int              ITEM_TARGET = 1750;
   localparam int              IDLE_LIMIT  = 2000;
   localparam int              LONG_HOLD   = 250;
   localparam int              HOLD_AFTER  = 400;
   localparam logic [deq_pkg::CMD_W-1:0] CMD_UNUSED = 3'd7;

   localparam int MODE_GROW   = 0;
   localparam int MODE_SHRINK = 1;
   localparam int MODE_MIXED  = 2;

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   logic [deq_pkg::CMD_W-1:0]         req_command;
   logic signed [deq_pkg::WORD_W-1:0] req_push_value;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic signed [deq_pkg::WORD_W-1:0] rsp_read_value;
   logic [deq_pkg::STAT_W-1:0]        rsp_status;
   logic [deq_pkg::OCC_W-1:0]         rsp_occupancy;
   logic                              rsp_is_empty;
   logic                              rsp_is_full;

   int fail_count;
   int outstanding;
   int items_sent  = 0;
   int burst_left  = 8;
   int rsp_taken   = 0;
   int idle_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   double_ended_queue #(.CAPACITY(CAPACITY)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_occupancy  (rsp_occupancy),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_is_full    (rsp_is_full)
   );

   deq_response_checker #(.CAPACITY(CAPACITY)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_occupancy  (rsp_occupancy),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_is_full    (rsp_is_full),
      .fail_count     (fail_count),
      .outstanding    (outstanding)
   );

   function automatic logic [deq_pkg::WORD_W-1:0] pick_word();
      int roll;
      roll = $urandom_range(0, 15);
      case (roll)
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [deq_pkg::CMD_W-1:0] pick_command(input int mode);
      int roll;
      int push_share;
      int pop_share;
      roll = $urandom_range(0, 99);
      push_share = (mode == MODE_GROW) ? 75 : (mode == MODE_SHRINK) ? 20 : 45;
      pop_share = (mode == MODE_GROW) ? 15 : (mode == MODE_SHRINK) ? 60 : 35;
      if (roll < 1) return deq_pkg::CMD_CLEAR;
      if (roll < 3) return CMD_UNUSED;
      if (roll < 3 + push_share)
         return $urandom_range(0, 1) ? deq_pkg::CMD_PUSH_BACK : deq_pkg::CMD_PUSH_FRONT;
      if (roll < 3 + push_share + pop_share)
         return $urandom_range(0, 1) ? deq_pkg::CMD_POP_BACK : deq_pkg::CMD_POP_FRONT;
      return $urandom_range(0, 1) ? deq_pkg::CMD_PEEK_BACK : deq_pkg::CMD_PEEK_FRONT;
   endfunction

   // Offer one transaction, hold it until taken, then idle between bursts
   task automatic send_item(input logic [deq_pkg::CMD_W-1:0] cmd,
                            input logic [deq_pkg::WORD_W-1:0] word);
      int gap;
      req_valid = 1'b1;
      req_command = cmd;
      req_push_value = word;
      do @(posedge clock); while (req_stall !== 1'b0);
      @(negedge clock);
      items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         gap = $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 20);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // Fill past full from both ends, then empty past underflow
   task automatic fill_and_drain();
      send_item(deq_pkg::CMD_CLEAR, pick_word());
      repeat (CAPACITY + 3)
         send_item($urandom_range(0, 1) ? deq_pkg::CMD_PUSH_BACK : deq_pkg::CMD_PUSH_FRONT,
                   pick_word());
      send_item(deq_pkg::CMD_PEEK_FRONT, pick_word());
      send_item(deq_pkg::CMD_PEEK_BACK, pick_word());
      repeat (CAPACITY + 3)
         send_item($urandom_range(0, 1) ? deq_pkg::CMD_POP_BACK : deq_pkg::CMD_POP_FRONT,
                   pick_word());
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            rsp_taken <= rsp_taken + 1;
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Receiver: stall patterns in stretches, plus one long hold-off
   initial begin
      int       stretch_left;
      int       hold_left;
      int       stall_mode;
      logic [7:0] stall_pattern;
      bit       hold_done;
      stretch_left = 0;
      hold_left = 0;
      stall_mode = 0;
      stall_pattern = '0;
      hold_done = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && rsp_taken >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            rsp_stall = 1'b1;
         end else if (hold_left > 0) begin
            hold_left--;
         end else begin
            if (stretch_left == 0) begin
               stretch_left = $urandom_range(10, 80);
               stall_mode = $urandom_range(0, 3);
               stall_pattern = 8'($urandom);
            end
            stretch_left--;
            case (stall_mode)
               0: rsp_stall = 1'b0;
               1: rsp_stall = 1'($urandom_range(0, 1));
               2: begin
                  rsp_stall = stall_pattern[0];
                  stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
               end
               default: rsp_stall = ($urandom_range(0, 4) != 0);
            endcase
         end
      end
   end

   initial begin
      int mode;
      int segment;
      bit midway_done;
      midway_done = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = deq_pkg::CMD_CLEAR;
      req_push_value = '0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // underflow on every read form, no-ops on an empty queue, then pushes, peeks and pops at both ends
      send_item(deq_pkg::CMD_POP_FRONT, '0);
      send_item(deq_pkg::CMD_POP_BACK, '0);
      send_item(deq_pkg::CMD_PEEK_FRONT, '0);
      send_item(deq_pkg::CMD_PEEK_BACK, '0);
      send_item(CMD_UNUSED, '0);
      send_item(deq_pkg::CMD_CLEAR, '1);
      send_item(deq_pkg::CMD_PUSH_FRONT, 32'h7fff_ffff);
      send_item(deq_pkg::CMD_PUSH_BACK, 32'h8000_0000);
      send_item(deq_pkg::CMD_PUSH_FRONT, '1);
      send_item(deq_pkg::CMD_PUSH_BACK, '0);
      send_item(deq_pkg::CMD_PEEK_FRONT, '0);
      send_item(deq_pkg::CMD_PEEK_BACK, '0);
      send_item(deq_pkg::CMD_POP_BACK, '0);
      send_item(deq_pkg::CMD_POP_FRONT, '0);
      send_item(CMD_UNUSED, '1);
      send_item(deq_pkg::CMD_PUSH_BACK, 32'h5555_5555);
      send_item(deq_pkg::CMD_PUSH_FRONT, 32'haaaa_aaaa);
      send_item(deq_pkg::CMD_CLEAR, '0);
      send_item(deq_pkg::CMD_PEEK_FRONT, '0);
      // both pointers wrap below zero
      send_item(deq_pkg::CMD_PUSH_FRONT, 32'h1234_5678);
      send_item(deq_pkg::CMD_POP_BACK, '0);
      wait_drained();

      fill_and_drain();
      while (items_sent < ITEM_TARGET) begin
         mode = $urandom_range(MODE_GROW, MODE_MIXED);
         segment = $urandom_range(30, 250);
         if (segment > ITEM_TARGET - items_sent) segment = ITEM_TARGET - items_sent;
         repeat (segment) send_item(pick_command(mode), pick_word());
         if (!midway_done && items_sent > 900) begin
            midway_done = 1'b1;
            wait_drained();
            fill_and_drain();
         end
      end

      wait_drained();
      repeat (8) @(negedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[filelist.f]
sv/deq_pkg.sv
sv/deq_datapath.sv
sv/deq_ctrl.sv
sv/double_ended_queue.sv
tb/sv/deq_response_checker.sv
tb/sv/tb_double_ended_queue.sv
